@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the parser RTL. They compile to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("%m: assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, ck, rn, prop)
`define ASSERT_NEVER(lbl, ck, rn, expr)
`endif

`endif

@@ rtl/gpp_pkg.sv @@
// ---------------------------------------------------------------------------
// gpp_pkg
// Types and constants shared by the GARP PDU parser modules.
// ---------------------------------------------------------------------------
`default_nettype none

package gpp_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 24;   // data_byte, frame_length
    localparam int OUT_TDATA_W = 40;   // 34 bits of fields, zero padded

    // register map
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_SAP = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_PID = 1'b1;

    localparam logic [7:0]  SAP_RESET = 8'h42;
    localparam logic [15:0] PID_RESET = 16'h0001;

    // protocol constants
    localparam logic [15:0] MIN_FRAME_LEN = 16'd5;
    localparam logic [7:0]  END_MARK      = 8'h00;
    localparam logic [7:0]  EVENT_MAX     = 8'd5;
    localparam int          EVENT_W       = 3;

    // result kinds
    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic               result_kind;
        logic [7:0]         value_byte;
        logic [4:0]         value_index;
        logic               accepted;
        logic               found_attribute;
        logic [7:0]         attribute_type;
        logic [EVENT_W-1:0] event_code;
        logic [7:0]         value_length;
        logic               last_result;
    } result_t;

    // results produced by one byte, first one goes out first
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

@@ rtl/gpp_cfg.sv @@
// ---------------------------------------------------------------------------
// gpp_cfg
// APB register file: SAP value and accepted protocol identifier.
// ---------------------------------------------------------------------------
`default_nettype none

module gpp_cfg
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  sap_value,
    output logic      [15:0] accepted_protocol_id
);

    logic [7:0]  sap_reg;
    logic [15:0] pid_reg;
    logic        wr_en;
    logic [gpp_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sap_reg <= gpp_pkg::SAP_RESET;
            pid_reg <= gpp_pkg::PID_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                gpp_pkg::REG_SAP: sap_reg <= pwdata[7:0];
                gpp_pkg::REG_PID: pid_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            gpp_pkg::REG_SAP: prdata = {24'b0, sap_reg};
            gpp_pkg::REG_PID: prdata = {16'b0, pid_reg};
            default:          prdata = 32'b0;
        endcase
    end

    assign sap_value            = sap_reg;
    assign accepted_protocol_id = pid_reg;

endmodule

`default_nettype wire

@@ rtl/gpp_parser.sv @@
// ---------------------------------------------------------------------------
// gpp_parser
// Input register plus one-pass byte parser: header checks, message walk,
// attribute report and frame verdict.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gpp_parser
#(
    parameter int MAX_ATTRS       = 16,
    parameter int MAX_VALUE_BYTES = 31
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_load,
    input  wire logic [7:0]  in_byte,
    input  wire logic [15:0] in_len,
    input  wire logic [7:0]  sap_value,
    input  wire logic [15:0] accepted_protocol_id,
    output gpp_pkg::push_t   push
);

    localparam int ACW = $clog2(MAX_ATTRS + 1);

    typedef enum logic [3:0] {
        PH_DSAP, PH_SSAP, PH_CTRL, PH_PID_HI, PH_PID_LO,
        PH_MSG, PH_ALEN, PH_EVENT, PH_VALUE, PH_DONE
    } phase_t;

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] in_len_reg;

    // parse state
    phase_t      phase_reg,  phase_next;
    logic [15:0] pos_reg,    pos_next;
    logic [15:0] total_reg,  total_next;
    logic [ACW-1:0] acnt_reg, acnt_next;
    logic [7:0]  left_reg,   left_next;
    logic [7:0]  mtype_reg,  mtype_next;
    logic [7:0]  pidhi_reg,  pidhi_next;
    logic        bad_reg,    bad_next;
    logic        found_reg,  found_next;
    logic        stream_reg, stream_next;
    logic [7:0]  rtype_reg,  rtype_next;
    logic [gpp_pkg::EVENT_W-1:0] revt_reg, revt_next;
    logic [7:0]  rvlen_reg,  rvlen_next;
    logic [4:0]  vcnt_reg,   vcnt_next;

    logic        emit_val;
    logic        verdict;
    logic [7:0]  b;
    gpp_pkg::result_t val_res;
    gpp_pkg::result_t ver_res;

    assign b = in_byte_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        total_next  = total_reg;
        acnt_next   = acnt_reg;
        left_next   = left_reg;
        mtype_next  = mtype_reg;
        pidhi_next  = pidhi_reg;
        bad_next    = bad_reg;
        found_next  = found_reg;
        stream_next = stream_reg;
        rtype_next  = rtype_reg;
        revt_next   = revt_reg;
        rvlen_next  = rvlen_reg;
        vcnt_next   = vcnt_reg;
        emit_val    = 1'b0;
        val_res     = '0;

        // first byte of a frame starts a fresh context
        if (pos_reg == 16'd0)
        begin
            total_next  = (in_len_reg == 16'd0) ? 16'd1 : in_len_reg;
            phase_next  = PH_DSAP;
            bad_next    = (total_next < gpp_pkg::MIN_FRAME_LEN);
            found_next  = 1'b0;
            stream_next = 1'b0;
            rtype_next  = '0;
            revt_next   = '0;
            rvlen_next  = '0;
            acnt_next   = '0;
            left_next   = '0;
            mtype_next  = '0;
            pidhi_next  = '0;
            vcnt_next   = '0;
        end

        if (!bad_next)
        begin
            case (phase_next)
                PH_DSAP:
                begin
                    if (b != sap_value) bad_next = 1'b1;
                    else                phase_next = PH_SSAP;
                end
                PH_SSAP:
                begin
                    if (b != sap_value) bad_next = 1'b1;
                    else                phase_next = PH_CTRL;
                end
                PH_CTRL:
                    phase_next = PH_PID_HI;
                PH_PID_HI:
                begin
                    pidhi_next = b;
                    phase_next = PH_PID_LO;
                end
                PH_PID_LO:
                begin
                    if ({pidhi_next, b} != accepted_protocol_id) bad_next = 1'b1;
                    else                                         phase_next = PH_MSG;
                end
                PH_MSG:
                begin
                    if (b == gpp_pkg::END_MARK)
                        phase_next = PH_DONE;
                    else
                    begin
                        mtype_next = b;
                        acnt_next  = '0;
                        phase_next = PH_ALEN;
                    end
                end
                PH_ALEN:
                begin
                    // a bad length byte is reread as the next message type
                    if ((acnt_next >= ACW'(MAX_ATTRS)) || (b == 8'd1) ||
                        (({1'b0, pos_next} + {9'b0, b}) > {1'b0, total_next}))
                    begin
                        if (b == gpp_pkg::END_MARK)
                            phase_next = PH_DONE;
                        else
                        begin
                            mtype_next = b;
                            acnt_next  = '0;
                            phase_next = PH_ALEN;
                        end
                    end
                    else if (b == gpp_pkg::END_MARK)
                        phase_next = PH_MSG;
                    else
                    begin
                        left_next  = b - 8'd1;
                        acnt_next  = acnt_next + ACW'(1);
                        phase_next = PH_EVENT;
                    end
                end
                PH_EVENT:
                begin
                    left_next = left_next - 8'd1;
                    if (!found_next && (b <= gpp_pkg::EVENT_MAX))
                    begin
                        found_next  = 1'b1;
                        stream_next = 1'b1;
                        rtype_next  = mtype_next;
                        revt_next   = b[gpp_pkg::EVENT_W-1:0];
                        rvlen_next  = left_next;
                        vcnt_next   = '0;
                    end
                    if (left_next == 8'd0)
                    begin
                        stream_next = 1'b0;
                        phase_next  = PH_ALEN;
                    end
                    else
                        phase_next = PH_VALUE;
                end
                PH_VALUE:
                begin
                    if (stream_next && (vcnt_next < 5'(MAX_VALUE_BYTES)))
                    begin
                        emit_val                = 1'b1;
                        val_res.result_kind     = gpp_pkg::KIND_VALUE;
                        val_res.value_byte      = b;
                        val_res.value_index     = vcnt_next;
                        val_res.accepted        = 1'b1;
                        val_res.found_attribute = found_next;
                        val_res.attribute_type  = rtype_next;
                        val_res.event_code      = revt_next;
                        val_res.value_length    = rvlen_next;
                        vcnt_next               = vcnt_next + 5'd1;
                    end
                    left_next = left_next - 8'd1;
                    if (left_next == 8'd0)
                    begin
                        stream_next = 1'b0;
                        phase_next  = PH_ALEN;
                    end
                end
                default: ;
            endcase
        end

        // frame end: verdict and rewind
        verdict = ({1'b0, pos_reg} + 17'd1) >= {1'b0, total_next};
        ver_res                 = '0;
        ver_res.result_kind     = gpp_pkg::KIND_VERDICT;
        ver_res.accepted        = !bad_next;
        ver_res.found_attribute = found_next;
        ver_res.attribute_type  = rtype_next;
        ver_res.event_code      = revt_next;
        ver_res.value_length    = rvlen_next;
        ver_res.last_result     = 1'b1;
        val_res.last_result     = !verdict;

        if (verdict)
        begin
            pos_next   = 16'd0;
            phase_next = PH_DSAP;
        end
        else
            pos_next = pos_reg + 16'd1;
    end

    always_comb
    begin
        push = '0;
        if (in_valid_reg)
        begin
            if (emit_val)
            begin
                push.first  = val_res;
                push.second = ver_res;
                push.count  = verdict ? 2'd2 : 2'd1;
            end
            else
            begin
                push.first = ver_res;
                push.count = verdict ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_byte_reg <= in_byte;
            in_len_reg  <= in_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_DSAP;
            pos_reg      <= '0;
            total_reg    <= '0;
            acnt_reg     <= '0;
            left_reg     <= '0;
            mtype_reg    <= '0;
            pidhi_reg    <= '0;
            bad_reg      <= 1'b0;
            found_reg    <= 1'b0;
            stream_reg   <= 1'b0;
            rtype_reg    <= '0;
            revt_reg     <= '0;
            rvlen_reg    <= '0;
            vcnt_reg     <= '0;
        end
        else
        begin
            in_valid_reg <= in_load;
            if (in_valid_reg)
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                total_reg  <= total_next;
                acnt_reg   <= acnt_next;
                left_reg   <= left_next;
                mtype_reg  <= mtype_next;
                pidhi_reg  <= pidhi_next;
                bad_reg    <= bad_next;
                found_reg  <= found_next;
                stream_reg <= stream_next;
                rtype_reg  <= rtype_next;
                revt_reg   <= revt_next;
                rvlen_reg  <= rvlen_next;
                vcnt_reg   <= vcnt_next;
            end
        end
    end

    // a streamed value byte always belongs to a reported attribute
    `ASSERT_PROP(a_value_has_attr, clk, rst_n, (in_valid_reg && emit_val) |-> (found_next && !bad_next))
    // a verdict rewinds to the first byte of the next frame
    `ASSERT_PROP(a_verdict_rewinds, clk, rst_n, (in_valid_reg && verdict) |=> (pos_reg == 16'd0))

endmodule

`default_nettype wire

@@ rtl/gpp_result_fifo.sv @@
// ---------------------------------------------------------------------------
// gpp_result_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gpp_result_fifo
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gpp_pkg::push_t push,
    input  wire logic           pop,
    output gpp_pkg::result_t    head,
    output logic                head_valid,
    output logic [gpp_pkg::RES_CNT_W-1:0] count
);

    localparam int SUM_W = gpp_pkg::RES_CNT_W + 1;

    gpp_pkg::result_t mem [gpp_pkg::RES_DEPTH];

    logic [gpp_pkg::RES_PTR_W-1:0] wptr_reg, wptr_next;
    logic [gpp_pkg::RES_PTR_W-1:0] rptr_reg, rptr_next;
    logic [gpp_pkg::RES_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [gpp_pkg::RES_PTR_W-1:0] wptr_p1;
    logic [SUM_W-1:0]              fill_sum;

    assign wptr_p1   = wptr_reg + gpp_pkg::RES_PTR_W'(1);
    assign wptr_next = wptr_reg + gpp_pkg::RES_PTR_W'(push.count);
    assign rptr_next = rptr_reg + gpp_pkg::RES_PTR_W'(pop);
    assign cnt_next  = cnt_reg + gpp_pkg::RES_CNT_W'(push.count)
                       - gpp_pkg::RES_CNT_W'(pop);

    // occupancy plus this cycle's pushes, before any pop
    assign fill_sum  = {1'b0, cnt_reg} + SUM_W'(push.count);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wptr_p1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign head       = mem[rptr_reg];
    assign head_valid = (cnt_reg != '0);
    assign count      = cnt_reg;

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, fill_sum > SUM_W'(gpp_pkg::RES_DEPTH))
    `ASSERT_PROP(a_pop_nonempty, clk, rst_n, pop |-> head_valid)

endmodule

`default_nettype wire

@@ rtl/garp_pdu_parser_unit.sv @@
// ---------------------------------------------------------------------------
// garp_pdu_parser_unit
// GARP PDU parser: checks LLC header and protocol id, walks messages and
// attributes, streams the first known attribute's value and a frame verdict.
// ---------------------------------------------------------------------------
// Usage:
//  - s_* stream: one LLC frame byte per beat, starting at DSAP. s_tdata holds
//    the byte and the total frame length (read only on a frame's first beat).
//  - m_* stream: result beats. m_tuser tells a value byte (0) from the frame
//    verdict (1); m_tlast marks the last result caused by one input beat.
//  - APB port: SAP value at 0x0, accepted protocol id at 0x4. Write only
//    while the block is idle.
//  - Throughput: one input beat per cycle while s_tready is high. A byte
//    that causes two results (a value byte on the frame's last byte) pushes
//    both into the queue at once; a four-entry result queue absorbs that
//    and back-pressure from m_tready.
//  - s_tready drops only when the queue could not hold the results of the
//    staged beat plus the worst case of two more; a stalled receiver thus
//    stalls the input and nothing is lost.
//  - Reset: registers return to 0x42 / 0x0001, the parser waits for DSAP and
//    the result queue empties.
// ---------------------------------------------------------------------------
`default_nettype none

module garp_pdu_parser_unit
#(
    parameter int MAX_ATTRS       = 16,
    parameter int MAX_VALUE_BYTES = 31
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [gpp_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] data_byte, [23:8] frame_length
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [gpp_pkg::OUT_TDATA_W-1:0] m_tdata,  // [7:0] value_byte, [12:8] value_index,
                                                      // [13] accepted, [14] found_attribute,
                                                      // [22:15] attribute_type,
                                                      // [25:23] event_code,
                                                      // [33:26] value_length, rest zero
    output logic             m_tuser,   // [0] result_kind
    output logic             m_tlast,   // last_result
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int SUM_W = gpp_pkg::RES_CNT_W + 1;

    logic        s_accept;
    logic        pop;
    logic [7:0]  sap_value;
    logic [15:0] accepted_protocol_id;
    logic [gpp_pkg::RES_CNT_W-1:0] q_count;
    logic [SUM_W-1:0] need;
    logic [SUM_W-1:0] room;

    gpp_pkg::push_t   push;
    gpp_pkg::result_t head;

    gpp_cfg u_cfg
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .sap_value            (sap_value),
        .accepted_protocol_id (accepted_protocol_id)
    );

    gpp_parser
    #(
        .MAX_ATTRS       (MAX_ATTRS),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    )
    u_parser
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_load              (s_accept),
        .in_byte              (s_tdata[7:0]),
        .in_len               (s_tdata[23:8]),
        .sap_value            (sap_value),
        .accepted_protocol_id (accepted_protocol_id),
        .push                 (push)
    );

    gpp_result_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (m_tvalid),
        .count      (q_count)
    );

    // room for what the staged beat pushes now plus two for a new beat
    assign need     = {1'b0, q_count} + SUM_W'(push.count) + SUM_W'(2);
    assign room     = SUM_W'(gpp_pkg::RES_DEPTH) + SUM_W'(pop);
    assign s_tready = (need <= room);
    assign s_accept = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    assign m_tdata = {6'b0, head.value_length, head.event_code, head.attribute_type,
                      head.found_attribute, head.accepted, head.value_index,
                      head.value_byte};
    assign m_tuser = head.result_kind;
    assign m_tlast = head.last_result;

endmodule

`default_nettype wire

@@ sim/garp_pdu_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// garp_pdu_checker
// Watches the byte, result and APB channels of the GARP PDU parser. It keeps
// its own copy of the parser state and registers. From every accepted byte
// beat it predicts the result beats, and it compares each result beat with
// the oldest prediction.
// ----------------------------------------------------------------------------

module garp_pdu_checker
#(
    parameter int MAX_ATTRS       = 16,
    parameter int MAX_VALUE_BYTES = 31
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [gpp_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [gpp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               m_tuser,
    input  logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output int unsigned                        pending_results,
    output int unsigned                        error_count
);

    typedef enum logic [3:0]
    {
        P_DSAP, P_SSAP, P_CTRL, P_PID_HI, P_PID_LO,
        P_MSG, P_ALEN, P_EVENT, P_VALUE, P_DONE
    } walk_phase_t;

    // register copies
    logic [7:0]  sap_cfg;
    logic [15:0] pid_cfg;

    // parser copy
    int unsigned  pos;
    int unsigned  total;
    walk_phase_t  phase;
    int unsigned  attr_cnt;
    logic [7:0]   bytes_left;
    logic [7:0]   walk_type;
    logic [7:0]   pid_hi;
    logic         bad;
    logic         attr_found;
    logic         streaming;
    logic [7:0]   rep_type;
    logic [2:0]   rep_event;
    logic [7:0]   rep_vlen;
    logic [4:0]   value_cnt;

    gpp_pkg::result_t garp_results[$];
    int unsigned      mismatches = 0;

    assign error_count = mismatches;

    function automatic gpp_pkg::result_t make_result(input logic kind, input logic [7:0] vb,
                                                     input logic [4:0] vi, input logic acc,
                                                     input logic last);
        gpp_pkg::result_t r;
        r.result_kind     = kind;
        r.value_byte      = vb;
        r.value_index     = vi;
        r.accepted        = acc;
        r.found_attribute = attr_found;
        r.attribute_type  = attr_found ? rep_type : 8'd0;
        r.event_code      = attr_found ? rep_event : 3'd0;
        r.value_length    = attr_found ? rep_vlen : 8'd0;
        r.last_result     = last;
        return r;
    endfunction

    // a type byte of zero ends the PDU
    task automatic take_type_byte(input logic [7:0] b);
        if (b == gpp_pkg::END_MARK)
            phase = P_DONE;
        else
        begin
            walk_type = b;
            attr_cnt  = 0;
            phase     = P_ALEN;
        end
    endtask

    task automatic parse_garp_byte(input logic [7:0] b, input logic [15:0] len);
        gpp_pkg::result_t r;
        int unsigned      made;
        made = 0;
        if (pos == 0)
        begin
            total      = (len == 16'd0) ? 1 : len;
            phase      = P_DSAP;
            bad        = (total < gpp_pkg::MIN_FRAME_LEN);
            attr_found = 1'b0;
            streaming  = 1'b0;
            rep_type   = '0;
            rep_event  = '0;
            rep_vlen   = '0;
            attr_cnt   = 0;
            bytes_left = '0;
            walk_type  = '0;
            pid_hi     = '0;
            value_cnt  = '0;
        end
        if (!bad)
        begin
            case (phase)
                P_DSAP:   if (b != sap_cfg) bad = 1'b1; else phase = P_SSAP;
                P_SSAP:   if (b != sap_cfg) bad = 1'b1; else phase = P_CTRL;
                P_CTRL:   phase = P_PID_HI;
                P_PID_HI:
                begin
                    pid_hi = b;
                    phase  = P_PID_LO;
                end
                P_PID_LO: if ({pid_hi, b} != pid_cfg) bad = 1'b1; else phase = P_MSG;
                P_MSG:    take_type_byte(b);
                P_ALEN:
                begin
                    if (attr_cnt >= MAX_ATTRS)
                        take_type_byte(b);
                    else if (b == gpp_pkg::END_MARK)
                        phase = P_MSG;
                    else if (b < 8'd2 || pos + b > total)
                        take_type_byte(b);
                    else
                    begin
                        bytes_left = b - 8'd1;
                        attr_cnt++;
                        phase = P_EVENT;
                    end
                end
                P_EVENT:
                begin
                    bytes_left = bytes_left - 8'd1;
                    if (!attr_found && b <= gpp_pkg::EVENT_MAX)
                    begin
                        attr_found = 1'b1;
                        streaming  = 1'b1;
                        rep_type   = walk_type;
                        rep_event  = b[2:0];
                        rep_vlen   = bytes_left;
                        value_cnt  = '0;
                    end
                    if (bytes_left == 8'd0)
                    begin
                        streaming = 1'b0;
                        phase     = P_ALEN;
                    end
                    else
                        phase = P_VALUE;
                end
                P_VALUE:
                begin
                    if (streaming && value_cnt < MAX_VALUE_BYTES)
                    begin
                        garp_results.push_back(make_result(gpp_pkg::KIND_VALUE, b,
                                                           value_cnt, 1'b1, 1'b0));
                        made++;
                        value_cnt++;
                    end
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0)
                    begin
                        streaming = 1'b0;
                        phase     = P_ALEN;
                    end
                end
                default: ;
            endcase
        end
        if (pos + 1 >= total)
        begin
            garp_results.push_back(make_result(gpp_pkg::KIND_VERDICT, 8'd0, 5'd0,
                                               !bad, 1'b1));
            pos   = 0;
            phase = P_DSAP;
        end
        else
        begin
            pos++;
            if (made > 0)
            begin
                r = garp_results.pop_back();
                r.last_result = 1'b1;
                garp_results.push_back(r);
            end
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want_v,
                                 input int unsigned got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        gpp_pkg::result_t want;
        gpp_pkg::result_t got;
        if (!rst_n)
        begin
            sap_cfg    = gpp_pkg::SAP_RESET;
            pid_cfg    = gpp_pkg::PID_RESET;
            pos        = 0;
            total      = 0;
            phase      = P_DSAP;
            attr_cnt   = 0;
            bytes_left = '0;
            walk_type  = '0;
            pid_hi     = '0;
            bad        = 1'b0;
            attr_found = 1'b0;
            streaming  = 1'b0;
            rep_type   = '0;
            rep_event  = '0;
            rep_vlen   = '0;
            value_cnt  = '0;
            garp_results.delete();
            pending_results <= 0;
        end
        else
        begin
            // result beats come from earlier byte beats, so check them first
            if (m_tvalid && m_tready)
            begin
                got.result_kind     = m_tuser;
                got.value_byte      = m_tdata[7:0];
                got.value_index     = m_tdata[12:8];
                got.accepted        = m_tdata[13];
                got.found_attribute = m_tdata[14];
                got.attribute_type  = m_tdata[22:15];
                got.event_code      = m_tdata[25:23];
                got.value_length    = m_tdata[33:26];
                got.last_result     = m_tlast;
                if (garp_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing pending, tuser %0h tdata 0x%0h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = garp_results.pop_front();
                    compare_field("result_kind", want.result_kind, got.result_kind);
                    compare_field("value_byte", want.value_byte, got.value_byte);
                    compare_field("value_index", want.value_index, got.value_index);
                    compare_field("accepted", want.accepted, got.accepted);
                    compare_field("found_attribute", want.found_attribute,
                                  got.found_attribute);
                    compare_field("attribute_type", want.attribute_type,
                                  got.attribute_type);
                    compare_field("event_code", want.event_code, got.event_code);
                    compare_field("value_length", want.value_length, got.value_length);
                    compare_field("last_result", want.last_result, got.last_result);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2 +: gpp_pkg::REG_IDX_W] == gpp_pkg::REG_SAP)
                    sap_cfg = pwdata[7:0];
                else if (paddr[2 +: gpp_pkg::REG_IDX_W] == gpp_pkg::REG_PID)
                    pid_cfg = pwdata[15:0];
            end
            if (s_tvalid && s_tready)
                parse_garp_byte(s_tdata[7:0], s_tdata[23:8]);
            pending_results <= garp_results.size();
        end
    end

endmodule

@@ sim/tb_garp_pdu_parser_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_garp_pdu_parser_unit
// Drives LLC frames into the GARP PDU parser: a few hand-built frames, then
// random GARP PDUs and junk frames under several SAP / protocol id settings.
// Both stream sides idle at random; one long receiver stall backs up the
// parser. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_garp_pdu_parser_unit;

    localparam int MAX_ATTRS       = 16;
    localparam int MAX_VALUE_BYTES = 31;
    localparam int HOLD_CYCLES     = 300;   // long receiver stall
    localparam int PHASE_BEATS     = 190;   // minimum byte beats per register setting

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [gpp_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] data_byte, [23:8] frame_length
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [gpp_pkg::OUT_TDATA_W-1:0] m_tdata;         // [7:0] value_byte, [12:8] value_index,
                                                      // [13] accepted, [14] found_attribute,
                                                      // [22:15] attribute_type,
                                                      // [25:23] event_code,
                                                      // [33:26] value_length, rest zero
    logic                            m_tuser;         // [0] result_kind
    logic                            m_tlast;         // last_result
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [2:0]                      paddr    = '0;
    logic [31:0]                     pwdata   = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    int unsigned            pending_results;
    int unsigned            error_count;

    // frame under construction and the register values it is built against
    logic [7:0]             frame_bytes[$];
    logic [7:0]             cur_sap  = gpp_pkg::SAP_RESET;
    logic [15:0]            cur_pid  = gpp_pkg::PID_RESET;
    bit                     steady   = 1'b0;    // no idling on either side
    logic                   hold_req = 1'b0;    // asks the receiver for a long stall
    int unsigned            beats_sent = 0;

    always #5 clk = ~clk;

    garp_pdu_parser_unit
    #(
        .MAX_ATTRS       (MAX_ATTRS),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    )
    DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    garp_pdu_checker
    #(
        .MAX_ATTRS       (MAX_ATTRS),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    )
    CHECK
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pending_results (pending_results),
        .error_count     (error_count)
    );

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // One byte beat. Called at a rising edge; returns at the edge that took it.
    // tvalid is only lowered when a gap really follows, so it is never dropped
    // and raised in the same step.
    task automatic send_beat(input logic [7:0] b, input logic [15:0] len);
        int gap;
        gap = steady ? 0 : idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {len, b};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    // Sends frame_bytes. Only the first beat's length matters to the parser;
    // later beats carry junk lengths, all ones now and then.
    task automatic send_frame(input logic [15:0] len);
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            send_beat(frame_bytes[i], (i == 0) ? len :
                      ($urandom_range(0, 9) == 0) ? 16'hFFFF :
                      16'($urandom_range(0, 65535)));
    endtask

    // APB write: setup beat, access beat, then a return to idle with psel low, so
    // that back to back writes never touch psel twice in one step.
    task automatic write_reg(input logic [gpp_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == gpp_pkg::REG_SAP)
            cur_sap = val[7:0];
        else
            cur_pid = val[15:0];
    endtask

    // Random GARP PDU: header mostly right, one to three messages with a few
    // attributes each. Covers bad headers, unknown events, long values, length
    // bytes of one or past the frame end, too many attributes, missing end
    // marks, an early end of PDU, and frames cut short or padded out.
    task automatic build_garp_frame(output logic [15:0] len);
        int         nattr;
        int         alen;
        int         k;
        int         size;
        logic [7:0] dsap;
        logic [7:0] ssap;
        logic [15:0] pid;
        frame_bytes.delete();
        dsap = cur_sap;
        ssap = cur_sap;
        pid  = cur_pid;
        case ($urandom_range(0, 29))
            0:       dsap = 8'($urandom_range(0, 255));
            1:       ssap = 8'($urandom_range(0, 255));
            2:       pid  = 16'($urandom_range(0, 65535));
            default: ;
        endcase
        frame_bytes.push_back(dsap);
        frame_bytes.push_back(ssap);
        frame_bytes.push_back(8'($urandom_range(0, 255)));  // LLC control, not checked
        frame_bytes.push_back(pid[15:8]);
        frame_bytes.push_back(pid[7:0]);
        repeat ($urandom_range(1, 3))
        begin
            // an end mark in place of a type ends the PDU early
            frame_bytes.push_back(($urandom_range(0, 19) == 0) ? gpp_pkg::END_MARK :
                                  8'($urandom_range(1, 255)));
            nattr = ($urandom_range(0, 9) == 0) ? MAX_ATTRS + $urandom_range(1, 2) :
                    $urandom_range(0, 4);
            repeat (nattr)
            begin
                k = $urandom_range(0, 99);
                if (nattr > MAX_ATTRS)
                    alen = 2;                           // runs past the attribute cap
                else if (k < 3)
                    alen = 1;
                else if (k < 5)
                    alen = $urandom_range(200, 255);
                else if (k < 15)
                    alen = $urandom_range(9, 40);       // 7 to 38 value bytes, some past the streamed cap
                else
                    alen = $urandom_range(2, 8);
                frame_bytes.push_back(8'(alen));
                if (alen >= 2)
                begin
                    frame_bytes.push_back(($urandom_range(0, 4) == 0) ?
                                          8'($urandom_range(6, 255)) :
                                          8'($urandom_range(0, 5)));
                    repeat (alen - 2)
                        frame_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 6) != 0)
                frame_bytes.push_back(gpp_pkg::END_MARK);
        end
        if ($urandom_range(0, 4) != 0)
            frame_bytes.push_back(gpp_pkg::END_MARK);
        repeat ($urandom_range(0, 3))
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        size = frame_bytes.size();
        k = $urandom_range(0, 99);
        if (k < 15)
            size = $urandom_range(1, size);
        else if (k < 25)
            size += $urandom_range(1, 8);
        while (frame_bytes.size() > size)
            void'(frame_bytes.pop_back());
        while (frame_bytes.size() < size)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        len = 16'(size);
    endtask

    // Junk frame, often too short; a length of zero still sends one byte.
    task automatic build_noise_frame(output logic [15:0] len);
        int n;
        n = $urandom_range(0, 12);
        frame_bytes.delete();
        repeat ((n == 0) ? 1 : n)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
            frame_bytes[0] = cur_sap;
        len = 16'(n);
    endtask

    // Receiver: random stalls, steady stretches, and one long hold-off on
    // request. Once lowered, tready is raised only after the stall has passed.
    initial
    begin
        int n;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                n = steady ? 0 : idle_cycles();
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int          ph;
        logic [15:0] len;
        int unsigned phase_start;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Hand-built frames under the reset settings:
        // zero length (taken as one byte), one byte, four bytes (too short)
        frame_bytes = '{8'hFF};
        send_frame(16'd0);
        frame_bytes = '{8'h00};
        send_frame(16'd1);
        frame_bytes = '{8'h42, 8'h42, 8'h03, 8'h00};
        send_frame(16'd4);
        // bare header, accepted with nothing found
        frame_bytes = '{8'h42, 8'h42, 8'h03, 8'h00, 8'h01};
        send_frame(16'd5);
        // one message, one JoinIn attribute with a two byte value
        frame_bytes = '{8'h42, 8'h42, 8'h03, 8'h00, 8'h01, 8'h01,
                        8'h04, 8'h02, 8'hAA, 8'h55};
        send_frame(16'd10);
        // wrong DSAP, then wrong protocol id
        frame_bytes = '{8'h43, 8'h42, 8'h03, 8'h00, 8'h01};
        send_frame(16'd5);
        frame_bytes = '{8'h42, 8'h42, 8'h03, 8'h00, 8'h02};
        send_frame(16'd5);

        // Random frames under five register settings: the reset values, the
        // extremes and a random one in between, then back to the reset values.
        for (ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                // idle: input lowered and every result in before the writes
                s_tvalid <= 1'b0;
                @(posedge clk);
                wait (pending_results == 0);
                repeat (4) @(posedge clk);
                case (ph)
                    1:
                    begin
                        write_reg(gpp_pkg::REG_SAP, 32'h0000_0000);
                        write_reg(gpp_pkg::REG_PID, 32'h0000_0000);
                    end
                    2:
                    begin
                        write_reg(gpp_pkg::REG_SAP, 32'h0000_00FF);
                        write_reg(gpp_pkg::REG_PID, 32'h0000_FFFF);
                    end
                    3:
                    begin
                        write_reg(gpp_pkg::REG_SAP, 32'($urandom_range(0, 255)));
                        write_reg(gpp_pkg::REG_PID, 32'($urandom_range(0, 65535)));
                    end
                    default:
                    begin
                        write_reg(gpp_pkg::REG_PID, {16'h0000, gpp_pkg::PID_RESET});
                        write_reg(gpp_pkg::REG_SAP, {24'h000000, gpp_pkg::SAP_RESET});
                    end
                endcase
            end
            // in phase two the sender streams flat out into a stalled receiver
            steady = (ph == 2) || ($urandom_range(0, 3) == 0);
            if (ph == 2)
                hold_req <= 1'b1;
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
            begin
                if ($urandom_range(0, 9) < 7)
                    build_garp_frame(len);
                else
                    build_noise_frame(len);
                send_frame(len);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_results == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit, well above the slowest legal run
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gpp_pkg.sv
rtl/gpp_cfg.sv
rtl/gpp_parser.sv
rtl/gpp_result_fifo.sv
rtl/garp_pdu_parser_unit.sv
sim/garp_pdu_checker.sv
sim/tb_garp_pdu_parser_unit.sv
